// File: rtl/irpde_pkg.sv
// ----------------------------------------------------------------------------
// irpde_pkg
// Shared types and constants of the IR pulse-distance encoder.
// ----------------------------------------------------------------------------
package irpde_pkg;

	localparam int MAX_DURATIONS = 1024;

	localparam int DUR_W   = 16;
	localparam int CODE_W  = 32;
	localparam int FMT_W   = 11;
	localparam int CIDX_W  = 4;
	localparam int CDATA_W = 16;
	localparam int STAT_W  = 2;
	localparam int LEN_W   = 17;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_HEADER_MARK  = 4'd0;
	localparam logic [CIDX_W-1:0] REG_HEADER_SPACE = 4'd1;
	localparam logic [CIDX_W-1:0] REG_BIT_MARK     = 4'd2;
	localparam logic [CIDX_W-1:0] REG_ONE_SPACE    = 4'd3;
	localparam logic [CIDX_W-1:0] REG_ZERO_SPACE   = 4'd4;
	localparam logic [CIDX_W-1:0] REG_STOP_MARK    = 4'd5;
	localparam logic [CIDX_W-1:0] REG_FRAME_GAP    = 4'd6;
	localparam logic [CIDX_W-1:0] REG_FRAME_FORMAT = 4'd7;

	// reset values
	localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 16'd4000;
	localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 16'd4000;
	localparam logic [DUR_W-1:0] RST_BIT_MARK     = 16'd500;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 16'd1000;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 16'd2000;
	localparam logic [DUR_W-1:0] RST_STOP_MARK    = 16'd500;
	localparam logic [DUR_W-1:0] RST_FRAME_GAP    = 16'd8500;
	localparam logic [FMT_W-1:0] RST_FRAME_FORMAT = 11'd1240;

	// input kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_NEXT  = 1'b1;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_IDLE     = 2'd1;
	localparam logic [STAT_W-1:0] ST_TOO_LONG = 2'd2;

	// sequence phase
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_DATA   = 2'd1;
	localparam logic [1:0] PH_STOP   = 2'd2;

	typedef struct packed {
		logic [DUR_W-1:0] header_mark;
		logic [DUR_W-1:0] header_space;
		logic [DUR_W-1:0] bit_mark;
		logic [DUR_W-1:0] one_space;
		logic [DUR_W-1:0] zero_space;
		logic [DUR_W-1:0] stop_mark;
		logic [DUR_W-1:0] frame_gap;
		logic [FMT_W-1:0] frame_format;
	} cfg_t;

endpackage

// File: rtl/irpde_if.sv
// ----------------------------------------------------------------------------
// irpde interfaces
// Input, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface irpde_in_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [irpde_pkg::CODE_W-1:0]   code_value;

	modport source (output valid, output kind, output code_value, input ready);
	modport sink   (input valid, input kind, input code_value, output ready);
endinterface

interface irpde_out_if;
	logic                           valid;
	logic                           ready;
	logic [irpde_pkg::DUR_W-1:0]    mark_us;
	logic [irpde_pkg::DUR_W-1:0]    space_us;
	logic                           last;
	logic [irpde_pkg::STAT_W-1:0]   status;

	modport source (output valid, output mark_us, output space_us, output last,
		output status, input ready);
	modport sink   (input valid, input mark_us, input space_us, input last,
		input status, output ready);
endinterface

interface irpde_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [irpde_pkg::CIDX_W-1:0]   index;
	logic [irpde_pkg::CDATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/irpde_cfg_regs.sv
// ----------------------------------------------------------------------------
// irpde_cfg_regs
// Timing and frame format registers, written over the config channel.
// ----------------------------------------------------------------------------
module irpde_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	irpde_cfg_if.sink         cfg_ch,
	output irpde_pkg::cfg_t   cfg
);

	irpde_pkg::cfg_t regs_q;
	logic            wr;

	assign cfg_ch.ready = 1'b1;
	assign wr           = cfg_ch.valid & cfg_ch.ready;
	assign cfg          = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.header_mark  <= irpde_pkg::RST_HEADER_MARK;
			regs_q.header_space <= irpde_pkg::RST_HEADER_SPACE;
			regs_q.bit_mark     <= irpde_pkg::RST_BIT_MARK;
			regs_q.one_space    <= irpde_pkg::RST_ONE_SPACE;
			regs_q.zero_space   <= irpde_pkg::RST_ZERO_SPACE;
			regs_q.stop_mark    <= irpde_pkg::RST_STOP_MARK;
			regs_q.frame_gap    <= irpde_pkg::RST_FRAME_GAP;
			regs_q.frame_format <= irpde_pkg::RST_FRAME_FORMAT;
		end else if (wr) begin
			case (cfg_ch.index)
				irpde_pkg::REG_HEADER_MARK:  regs_q.header_mark  <= cfg_ch.data;
				irpde_pkg::REG_HEADER_SPACE: regs_q.header_space <= cfg_ch.data;
				irpde_pkg::REG_BIT_MARK:     regs_q.bit_mark     <= cfg_ch.data;
				irpde_pkg::REG_ONE_SPACE:    regs_q.one_space    <= cfg_ch.data;
				irpde_pkg::REG_ZERO_SPACE:   regs_q.zero_space   <= cfg_ch.data;
				irpde_pkg::REG_STOP_MARK:    regs_q.stop_mark    <= cfg_ch.data;
				irpde_pkg::REG_FRAME_GAP:    regs_q.frame_gap    <= cfg_ch.data;
				irpde_pkg::REG_FRAME_FORMAT:
					regs_q.frame_format <= cfg_ch.data[irpde_pkg::FMT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// File: rtl/irpde_core.sv
// ----------------------------------------------------------------------------
// irpde_core
// Sequence state and next-pair logic with a registered result stage.
// ----------------------------------------------------------------------------
module irpde_core (
	input  logic              clk,
	input  logic              arst_n,
	input  irpde_pkg::cfg_t   cfg,
	irpde_in_if.sink          in_ch,
	irpde_out_if.source       out_ch
);

	// sequence state
	logic                           active_q;
	logic [irpde_pkg::CODE_W-1:0]   code_q;
	logic [3:0]                     frame_idx_q;
	logic [5:0]                     bit_idx_q;
	logic [1:0]                     phase_q;

	// result register
	logic                           out_valid_q;
	logic [irpde_pkg::DUR_W-1:0]    mark_q;
	logic [irpde_pkg::DUR_W-1:0]    space_q;
	logic                           last_q;
	logic [irpde_pkg::STAT_W-1:0]   status_q;

	logic                           acc;
	logic [5:0]                     bits;
	logic [3:0]                     frames;
	logic                           msb_first;
	logic [7:0]                     per_frame;
	logic [irpde_pkg::LEN_W-1:0]    total;
	logic [5:0]                     shift;
	logic                           bit_one;
	logic [5:0]                     bit_inc;
	logic                           do_stop;

	logic                           n_active;
	logic [irpde_pkg::CODE_W-1:0]   n_code;
	logic [3:0]                     n_frame;
	logic [5:0]                     n_bit;
	logic [1:0]                     n_phase;
	logic [irpde_pkg::DUR_W-1:0]    r_mark;
	logic [irpde_pkg::DUR_W-1:0]    r_space;
	logic                           r_last;
	logic [irpde_pkg::STAT_W-1:0]   r_status;

	assign in_ch.ready    = !out_valid_q || out_ch.ready;
	assign acc            = in_ch.valid && in_ch.ready;

	assign out_ch.valid    = out_valid_q;
	assign out_ch.mark_us  = mark_q;
	assign out_ch.space_us = space_q;
	assign out_ch.last     = last_q;
	assign out_ch.status   = status_q;

	assign bits      = cfg.frame_format[5:0];
	assign frames    = (cfg.frame_format[9:6] == 4'd0) ? 4'd1 : cfg.frame_format[9:6];
	assign msb_first = cfg.frame_format[10];
	assign per_frame = 8'd3 + {1'b0, bits, 1'b0};
	assign total     = irpde_pkg::LEN_W'(per_frame) * irpde_pkg::LEN_W'(frames)
		+ irpde_pkg::LEN_W'(frames) - irpde_pkg::LEN_W'(1);

	assign shift   = msb_first ? (bits - 6'd1 - bit_idx_q) : bit_idx_q;
	assign bit_one = !shift[5] && code_q[shift[4:0]];
	assign bit_inc = bit_idx_q + 6'd1;

	always_comb begin
		n_active = active_q;
		n_code   = code_q;
		n_frame  = frame_idx_q;
		n_bit    = bit_idx_q;
		n_phase  = phase_q;
		r_mark   = '0;
		r_space  = '0;
		r_last   = 1'b0;
		r_status = irpde_pkg::ST_OK;
		do_stop  = 1'b0;
		if (in_ch.kind == irpde_pkg::KIND_START) begin
			n_active = 1'b0;
			n_frame  = '0;
			n_bit    = '0;
			n_phase  = irpde_pkg::PH_HEADER;
			if (total > irpde_pkg::LEN_W'(irpde_pkg::MAX_DURATIONS)) begin
				r_status = irpde_pkg::ST_TOO_LONG;
			end else begin
				n_code   = in_ch.code_value;
				n_active = 1'b1;
				r_mark   = cfg.header_mark;
				r_space  = cfg.header_space;
				n_phase  = (bits != 6'd0) ? irpde_pkg::PH_DATA : irpde_pkg::PH_STOP;
			end
		end else if (!active_q) begin
			r_status = irpde_pkg::ST_IDLE;
		end else begin
			case (phase_q)
				irpde_pkg::PH_HEADER: begin
					r_mark  = cfg.header_mark;
					r_space = cfg.header_space;
					n_bit   = '0;
					n_phase = (bits != 6'd0) ? irpde_pkg::PH_DATA : irpde_pkg::PH_STOP;
				end
				irpde_pkg::PH_DATA: begin
					if (bit_idx_q < bits) begin
						r_mark  = cfg.bit_mark;
						r_space = bit_one ? cfg.one_space : cfg.zero_space;
						n_bit   = bit_inc;
						if (bit_inc >= bits || bit_inc == 6'd0)
							n_phase = irpde_pkg::PH_STOP;
					end else begin
						do_stop = 1'b1;
					end
				end
				default: do_stop = 1'b1;
			endcase
			if (do_stop) begin
				r_mark = cfg.stop_mark;
				n_bit  = '0;
				n_phase = irpde_pkg::PH_HEADER;
				if ({1'b0, frame_idx_q} + 5'd1 >= {1'b0, frames}) begin
					r_last   = 1'b1;
					n_active = 1'b0;
					n_frame  = '0;
				end else begin
					r_space = cfg.frame_gap;
					n_frame = frame_idx_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			code_q      <= '0;
			frame_idx_q <= '0;
			bit_idx_q   <= '0;
			phase_q     <= irpde_pkg::PH_HEADER;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				active_q    <= n_active;
				code_q      <= n_code;
				frame_idx_q <= n_frame;
				bit_idx_q   <= n_bit;
				phase_q     <= n_phase;
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mark_q   <= r_mark;
			space_q  <= r_space;
			last_q   <= r_last;
			status_q <= r_status;
		end
	end

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (frame_idx_q == 4'd0 && bit_idx_q == 6'd0
			&& phase_q == irpde_pkg::PH_HEADER))
		else $error("inactive sequence with stale counters");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		acc && r_last |=> !active_q && out_valid_q && last_q)
		else $error("final pair did not end the sequence");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		acc && in_ch.kind == irpde_pkg::KIND_NEXT && !active_q
		|=> !active_q && status_q == irpde_pkg::ST_IDLE)
		else $error("next with no sequence changed state");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != irpde_pkg::ST_OK
		|-> mark_q == '0 && space_q == '0 && !last_q)
		else $error("error result carries durations");

endmodule

// File: rtl/ir_pulse_distance_encoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder
// IR remote code to mark/space durations, one pair per pulled word.
//
//   channel  dir  handshake          word
//   in_ch    in   valid/ready        kind, code_value
//   out_ch   out  valid/ready        mark_us, space_us, last, status
//   cfg_ch   in   valid/ready (rdy=1) index, data
//
// One input word per cycle while in_ch is ready; its result is registered and shows in the cycle
// after acceptance. A single output register decouples the sides: in_ch is
// ready whenever that register is empty or being drained this cycle.
// arst_n clears the sequence state and loads the register defaults.
// ----------------------------------------------------------------------------
module ir_pulse_distance_encoder (
	input  logic          clk,
	input  logic          arst_n,
	irpde_in_if.sink      in_ch,
	irpde_out_if.source   out_ch,
	irpde_cfg_if.sink     cfg_ch
);

	irpde_pkg::cfg_t cfg;

	irpde_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	irpde_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

// File: verif/irpde_pair_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irpde_pair_checker
// Watches the config, input and result channels of the IR pulse-distance
// encoder, works out the mark/space pair each input word should give and
// compares every result word with the oldest pair still due.
// ----------------------------------------------------------------------------
module irpde_pair_checker
	import irpde_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	irpde_in_if   in_ch,
	irpde_out_if  out_ch,
	irpde_cfg_if  cfg_ch,
	output int    mismatches,
	output int    pairs_due
);

	typedef struct packed {
		logic [DUR_W-1:0]  mark_us;
		logic [DUR_W-1:0]  space_us;
		logic              last;
		logic [STAT_W-1:0] status;
	} pair_t;

	cfg_t              regs;
	logic              seq_on;
	logic [CODE_W-1:0] code_q;
	logic [3:0]        frame_q;
	logic [5:0]        bit_q;
	logic [1:0]        phase_q;
	pair_t             due_pairs[$];
	int                err_count;

	function automatic pair_t header_pair();
		bit_q   = '0;
		phase_q = (regs.frame_format[5:0] != 0) ? PH_DATA : PH_STOP;
		return '{regs.header_mark, regs.header_space, 1'b0, ST_OK};
	endfunction

	function automatic pair_t encode_word(input logic kind, input logic [CODE_W-1:0] code);
		int    nbits;
		int    nframes;
		int    total;
		int    shift;
		logic  one;
		pair_t p;
		nbits   = int'(regs.frame_format[5:0]);
		nframes = (regs.frame_format[9:6] == 0) ? 1 : int'(regs.frame_format[9:6]);
		if (kind == KIND_START) begin
			total   = (3 + 2 * nbits) * nframes + nframes - 1;
			seq_on  = 1'b0;
			frame_q = '0;
			bit_q   = '0;
			phase_q = PH_HEADER;
			if (total > MAX_DURATIONS)
				return '{'0, '0, 1'b0, ST_TOO_LONG};
			code_q = code;
			seq_on = 1'b1;
			return header_pair();
		end
		if (!seq_on)
			return '{'0, '0, 1'b0, ST_IDLE};
		if (phase_q == PH_HEADER)
			return header_pair();
		if (phase_q == PH_DATA && int'(bit_q) < nbits) begin
			shift = regs.frame_format[10] ? nbits - 1 - int'(bit_q) : int'(bit_q);
			one   = (shift < CODE_W) ? code_q[shift] : 1'b0;
			p     = '{regs.bit_mark, one ? regs.one_space : regs.zero_space, 1'b0, ST_OK};
			bit_q = bit_q + 6'd1;
			if (int'(bit_q) >= nbits || bit_q == 0)
				phase_q = PH_STOP;
			return p;
		end
		// stop pair: gap to the next frame, or end of the whole sequence
		if (int'(frame_q) + 1 >= nframes) begin
			p       = '{regs.stop_mark, '0, 1'b1, ST_OK};
			seq_on  = 1'b0;
			frame_q = '0;
		end else begin
			p       = '{regs.stop_mark, regs.frame_gap, 1'b0, ST_OK};
			frame_q = frame_q + 4'd1;
		end
		bit_q   = '0;
		phase_q = PH_HEADER;
		return p;
	endfunction

	function automatic void check_field(input string field, input logic [DUR_W-1:0] want,
		input logic [DUR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			err_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pair_t want;
		if (!arst_n) begin
			regs      = '{RST_HEADER_MARK, RST_HEADER_SPACE, RST_BIT_MARK, RST_ONE_SPACE,
				RST_ZERO_SPACE, RST_STOP_MARK, RST_FRAME_GAP, RST_FRAME_FORMAT};
			seq_on    = 1'b0;
			code_q    = '0;
			frame_q   = '0;
			bit_q     = '0;
			phase_q   = PH_HEADER;
			err_count = 0;
			due_pairs.delete();
		end else begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_HEADER_MARK:  regs.header_mark  = cfg_ch.data;
					REG_HEADER_SPACE: regs.header_space = cfg_ch.data;
					REG_BIT_MARK:     regs.bit_mark     = cfg_ch.data;
					REG_ONE_SPACE:    regs.one_space    = cfg_ch.data;
					REG_ZERO_SPACE:   regs.zero_space   = cfg_ch.data;
					REG_STOP_MARK:    regs.stop_mark    = cfg_ch.data;
					REG_FRAME_GAP:    regs.frame_gap    = cfg_ch.data;
					REG_FRAME_FORMAT: regs.frame_format = cfg_ch.data[FMT_W-1:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				if (due_pairs.size() == 0) begin
					$error("unexpected word: mark_us %0d space_us %0d last %0d status %0d",
						out_ch.mark_us, out_ch.space_us, out_ch.last, out_ch.status);
					err_count++;
				end else begin
					want = due_pairs.pop_front();
					check_field("mark_us", want.mark_us, out_ch.mark_us);
					check_field("space_us", want.space_us, out_ch.space_us);
					check_field("last", DUR_W'(want.last), DUR_W'(out_ch.last));
					check_field("status", DUR_W'(want.status), DUR_W'(out_ch.status));
				end
			end
			if (in_ch.valid && in_ch.ready)
				due_pairs.push_back(encode_word(in_ch.kind, in_ch.code_value));
		end
		mismatches <= err_count;
		pairs_due  <= due_pairs.size();
	end

endmodule

// File: verif/ir_pulse_distance_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_encoder_tb
// Drives start/next words and register writes into the IR pulse-distance
// encoder: a directed opener, then random sequences under changing formats
// and handshake pressure. The pair checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module ir_pulse_distance_encoder_tb;
	import irpde_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 150;
	localparam int SEG_WORDS    = 20;
	localparam int SEGS         = 5;
	localparam int MAX_RUN      = 40;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	int               in_idle_pct   = 0;
	int               out_stall_pct = 0;
	int               holds_asked   = 0;
	int               mismatches;
	int               pairs_due;
	logic [FMT_W-1:0] fmt_now = RST_FRAME_FORMAT;
	int               idle_plan[4]  = '{0, 74, 0, 32};
	int               stall_plan[4] = '{0, 0, 74, 32};

	irpde_in_if  in_ch();
	irpde_out_if out_ch();
	irpde_cfg_if cfg_ch();

	ir_pulse_distance_encoder u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	irpde_pair_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.cfg_ch     (cfg_ch),
		.mismatches (mismatches),
		.pairs_due  (pairs_due)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [DUR_W-1:0] rand_duration();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return DUR_W'($urandom);
		endcase
	endfunction

	function automatic logic [CODE_W-1:0] rand_code();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input logic kind, input logic [CODE_W-1:0] code);
		if ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
		end
		in_ch.valid      <= 1'b1;
		in_ch.kind       <= kind;
		in_ch.code_value <= code;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pairs_due != 0);
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] index, input logic [CDATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		if (index == REG_FRAME_FORMAT)
			fmt_now = data[FMT_W-1:0];
	endtask

	task automatic apply_format(input logic [FMT_W-1:0] fmt);
		wait_drained();
		write_reg(REG_FRAME_FORMAT, CDATA_W'(fmt));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic shuffle_config();
		logic [FMT_W-1:0] fmt;
		fmt = FMT_W'($urandom);
		// mostly short frames so sequences run to their end
		if ($urandom_range(3) != 0) begin
			fmt[5:0] = 6'($urandom_range(12));
			fmt[9:6] = 4'($urandom_range(3));
		end
		wait_drained();
		write_reg(REG_HEADER_MARK, rand_duration());
		write_reg(REG_HEADER_SPACE, rand_duration());
		write_reg(REG_BIT_MARK, rand_duration());
		write_reg(REG_ONE_SPACE, rand_duration());
		write_reg(REG_ZERO_SPACE, rand_duration());
		write_reg(REG_STOP_MARK, rand_duration());
		write_reg(REG_FRAME_GAP, rand_duration());
		write_reg(REG_FRAME_FORMAT, CDATA_W'(fmt));
		write_reg(CIDX_W'($urandom_range(int'(REG_FRAME_FORMAT) + 1, (1 << CIDX_W) - 1)),
			CDATA_W'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic run_segment();
		int sent;
		int frames;
		int pairs;
		int nexts;
		sent   = 0;
		frames = (fmt_now[9:6] == 0) ? 1 : int'(fmt_now[9:6]);
		pairs  = frames * (int'(fmt_now[5:0]) + 2);
		while (sent < SEG_WORDS) begin
			case ($urandom_range(9))
				0: begin
					send_word(logic'($urandom), rand_code());
					sent++;
				end
				1: begin
					nexts = $urandom_range((pairs + 2 > MAX_RUN) ? MAX_RUN : pairs + 2);
					send_word(KIND_START, rand_code());
					repeat (nexts) send_word(KIND_NEXT, $urandom);
					sent += nexts + 1;
				end
				default: begin
					nexts = (pairs - 1 > MAX_RUN) ? MAX_RUN : pairs - 1 + $urandom_range(1);
					send_word(KIND_START, rand_code());
					repeat (nexts) send_word(KIND_NEXT, $urandom);
					sent += nexts + 1;
				end
			endcase
		end
	endtask

	initial begin : drive_ready
		int holds_done;
		int hold_left;
		holds_done = 0;
		hold_left  = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && holds_done < holds_asked) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else
				out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				quiet = 0;
			else if (++quiet >= IDLE_LIMIT) begin
				$display("ir_pulse_distance_encoder verification failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		in_ch.valid      <= 1'b0;
		in_ch.kind       <= KIND_START;
		in_ch.code_value <= '0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= REG_HEADER_MARK;
		cfg_ch.data      <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset format: next with nothing active, start, restart mid-sequence
		send_word(KIND_NEXT, '1);
		send_word(KIND_START, '1);
		send_word(KIND_NEXT, '0);
		send_word(KIND_NEXT, '0);
		send_word(KIND_START, 32'h0000_0001);
		send_word(KIND_NEXT, '0);

		// no data bits, repeat field zero: header then final stop
		apply_format('0);
		send_word(KIND_START, '1);
		send_word(KIND_NEXT, '0);
		send_word(KIND_NEXT, '0);

		// two frames of one LSB-first bit: gap, then final stop
		apply_format({1'b0, 4'd2, 6'd1});
		send_word(KIND_START, 32'h0000_0001);
		repeat (5) send_word(KIND_NEXT, '0);

		// too long at full format and just over the limit
		apply_format('1);
		send_word(KIND_START, '1);
		send_word(KIND_NEXT, '1);
		apply_format({1'b1, 4'd9, 6'd55});
		send_word(KIND_START, '1);

		// just fits; MSB-first positions above the code read zero
		apply_format({1'b1, 4'd9, 6'd54});
		send_word(KIND_START, '1);
		send_word(KIND_NEXT, '0);
		send_word(KIND_NEXT, '0);

		apply_format({1'b1, 4'd0, 6'd32});
		send_word(KIND_START, 32'h8000_0000);
		send_word(KIND_NEXT, '0);
		send_word(KIND_NEXT, '0);

		for (int ph = 0; ph < 4; ph++) begin
			in_idle_pct   = idle_plan[ph];
			out_stall_pct = stall_plan[ph];
			for (int seg = 0; seg < SEGS; seg++) begin
				shuffle_config();
				if (ph == 0 && seg == 1)
					holds_asked++;
				run_segment();
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && pairs_due == 0)
			$display("ir_pulse_distance_encoder verification clean");
		else
			$display("ir_pulse_distance_encoder verification failed");
		$finish;
	end

endmodule
